// ----- design/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and controller/datapath interface types of the
// bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int MAP_WORDS   = 2048;
	localparam int WORD_ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int MAP_PAGES   = MAP_WORDS * 32;
	// page pointer and run length width, holds a store size plus one word
	localparam int CUR_W       = (WORD_ADDR_W + 6 > 18) ? WORD_ADDR_W + 6 : 18;
	// scan word counter width, holds MAP_WORDS and any limit / 32
	localparam int SW_W        = (WORD_ADDR_W + 1 > 12) ? WORD_ADDR_W + 1 : 12;

	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int S_DATA_W  = 72;
	localparam int M_DATA_W  = 16;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_RESERVE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STRICT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PAGE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAGE = 2'd2;

	localparam logic [CFG_W-1:0] MAX_PAGE_RESET = 17'd65536;

	localparam logic [31:0] WORD_FULL  = 32'hffff_ffff;
	localparam logic [31:0] WORD_EMPTY = 32'h0;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMEM   = 2'd1,
		ST_BADARG  = 2'd2,
		ST_BADADDR = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_EVAL,
		S_SCAN_BIT,
		S_FOUND,
		S_MARK_RD,
		S_MARK_WR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    clr_step;
		logic    latch;
		logic    scan_init;
		logic    scan_read;
		logic    scan_word;
		logic    scan_bit;
		logic    scan_next;
		logic    mark_init_alloc;
		logic    mark_init_req;
		logic    mark_fill;
		logic    mark_read;
		logic    mark_write;
		logic    load_out;
		status_t out_status;
		logic    out_found;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [1:0] op;
		logic       alloc_bad;
		logic       free_bad;
		logic       scan_done;
		logic       word_zero;
		logic       word_full;
		logic       full_hit;
		logic       bit_hit;
		logic       bit_last;
		logic       mark_done;
	} dp_stat_t;

endpackage

// ----- design/bitmap_page_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a bitmap of free pages, with alloc, free and
// reserve commands on a stream interface.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap memory to all used, one word a
// cycle; s_tready stays low until then, while configuration writes are
// taken at once. One command is worked at a time. Every word is read from
// the single bitmap memory with its registered read: an alloc reads each
// word it scans, passes empty and full words whole and scans each mixed
// word bit by bit up to the hit, then reads and writes back each word the
// found run covers; free and reserve read and write back each word the run
// touches. The result sits in an output register, so a new command is taken
// while the previous result waits on m_tready.
module bitmap_page_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpa_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// start_page[15:0], page_count[32:16], lower_page[49:33], upper_page[66:50], zero
	input  logic [bpa_pkg::S_DATA_W-1:0]  s_tdata,
	// command[1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// result_page[15:0]
	output logic [bpa_pkg::M_DATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [1:0]                    m_tuser
);

	bpa_pkg::ctrl_cmd_t cmd;
	bpa_pkg::dp_stat_t  st;
	bpa_pkg::status_t   out_status;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bpa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_command    (s_tuser),
		.in_start_page (s_tdata[15:0]),
		.in_page_count (s_tdata[32:16]),
		.in_lower_page (s_tdata[49:33]),
		.in_upper_page (s_tdata[66:50]),
		.cmd           (cmd),
		.st            (st),
		.out_status    (out_status),
		.out_page      (m_tdata)
	);

	assign m_tuser = out_status;

endmodule

// ----- design/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpa_ctrl
// Command sequencer: clearing pass, decode, word scan, bit scan, run marking
// and result hand-off.
// ----------------------------------------------------------------------------
module bpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  bpa_pkg::dp_stat_t st,
	output bpa_pkg::ctrl_cmd_t cmd
);

	bpa_pkg::state_t  state_q, state_d;
	bpa_pkg::status_t rstat_q, rstat_d;
	logic             rfound_q, rfound_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpa_pkg::S_CLEAR;
			rstat_q     <= bpa_pkg::ST_OK;
			rfound_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rstat_q  <= rstat_d;
			rfound_q <= rfound_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		rstat_d  = rstat_q;
		rfound_d = rfound_q;
		case (state_q)
			bpa_pkg::S_CLEAR: begin
				if (st.clr_last) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			bpa_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = bpa_pkg::S_DECODE;
				end
			end
			bpa_pkg::S_DECODE: begin
				rfound_d = 1'b0;
				rstat_d  = bpa_pkg::ST_OK;
				case (st.op)
					bpa_pkg::OP_ALLOC: begin
						if (st.alloc_bad) begin
							rstat_d = bpa_pkg::ST_BADARG;
							state_d = bpa_pkg::S_RESP;
						end else begin
							state_d = bpa_pkg::S_SCAN_RD;
						end
					end
					bpa_pkg::OP_FREE: begin
						if (st.free_bad) begin
							rstat_d = bpa_pkg::ST_BADADDR;
							state_d = bpa_pkg::S_RESP;
						end else begin
							state_d = bpa_pkg::S_MARK_RD;
						end
					end
					bpa_pkg::OP_RESERVE: begin
						state_d = bpa_pkg::S_MARK_RD;
					end
					default: begin
						rstat_d = bpa_pkg::ST_BADARG;
						state_d = bpa_pkg::S_RESP;
					end
				endcase
			end
			bpa_pkg::S_SCAN_RD: begin
				if (st.scan_done) begin
					rstat_d = bpa_pkg::ST_NOMEM;
					state_d = bpa_pkg::S_RESP;
				end else begin
					state_d = bpa_pkg::S_SCAN_EVAL;
				end
			end
			bpa_pkg::S_SCAN_EVAL: begin
				if (st.word_zero) begin
					state_d = bpa_pkg::S_SCAN_RD;
				end else if (st.word_full) begin
					state_d = st.full_hit ? bpa_pkg::S_FOUND : bpa_pkg::S_SCAN_RD;
				end else begin
					state_d = bpa_pkg::S_SCAN_BIT;
				end
			end
			bpa_pkg::S_SCAN_BIT: begin
				if (st.bit_hit) begin
					state_d = bpa_pkg::S_FOUND;
				end else if (st.bit_last) begin
					state_d = bpa_pkg::S_SCAN_RD;
				end
			end
			bpa_pkg::S_FOUND: begin
				rfound_d = 1'b1;
				state_d  = bpa_pkg::S_MARK_RD;
			end
			bpa_pkg::S_MARK_RD: begin
				state_d = st.mark_done ? bpa_pkg::S_RESP : bpa_pkg::S_MARK_WR;
			end
			bpa_pkg::S_MARK_WR: begin
				state_d = bpa_pkg::S_MARK_RD;
			end
			bpa_pkg::S_RESP: begin
				if (out_free) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpa_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			bpa_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			bpa_pkg::S_IDLE: begin
				s_tready  = 1'b1;
				cmd.latch = s_tvalid;
			end
			bpa_pkg::S_DECODE: begin
				case (st.op)
					bpa_pkg::OP_ALLOC: begin
						cmd.scan_init = !st.alloc_bad;
					end
					bpa_pkg::OP_FREE: begin
						cmd.mark_init_req = !st.free_bad;
						cmd.mark_fill     = 1'b1;
					end
					bpa_pkg::OP_RESERVE: begin
						cmd.mark_init_req = 1'b1;
					end
					default: begin
						cmd.mark_fill = 1'b0;
					end
				endcase
			end
			bpa_pkg::S_SCAN_RD: begin
				cmd.scan_read = !st.scan_done;
			end
			bpa_pkg::S_SCAN_EVAL: begin
				cmd.scan_word = 1'b1;
				cmd.scan_next = st.word_zero || (st.word_full && !st.full_hit);
			end
			bpa_pkg::S_SCAN_BIT: begin
				cmd.scan_bit  = 1'b1;
				cmd.scan_next = !st.bit_hit && st.bit_last;
			end
			bpa_pkg::S_FOUND: begin
				cmd.mark_init_alloc = 1'b1;
			end
			bpa_pkg::S_MARK_RD: begin
				cmd.mark_read = !st.mark_done;
			end
			bpa_pkg::S_MARK_WR: begin
				cmd.mark_write = 1'b1;
			end
			bpa_pkg::S_RESP: begin
				cmd.load_out   = out_free;
				cmd.out_status = rstat_q;
				cmd.out_found  = rfound_q;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/bpa_dp.sv -----
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: configuration registers, command registers, page bitmap memory,
// scan counters, run marking and the result register.
// ----------------------------------------------------------------------------
module bpa_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpa_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [1:0]                     in_command,
	input  logic [15:0]                    in_start_page,
	input  logic [16:0]                    in_page_count,
	input  logic [16:0]                    in_lower_page,
	input  logic [16:0]                    in_upper_page,
	input  bpa_pkg::ctrl_cmd_t             cmd,
	output bpa_pkg::dp_stat_t              st,
	output bpa_pkg::status_t               out_status,
	output logic [15:0]                    out_page
);

	localparam int AW = bpa_pkg::WORD_ADDR_W;
	localparam int CW = bpa_pkg::CUR_W;
	localparam int SW = bpa_pkg::SW_W;

	// configuration
	logic        strict_q;
	logic [16:0] min_page_q;
	logic [16:0] max_page_q;

	// latched command
	logic [1:0]  op_q;
	logic [15:0] sp_q;
	logic [16:0] cnt_q;
	logic [16:0] lo_q;
	logic [16:0] hi_q;

	// scan and mark state
	logic [SW-1:0] w_q;
	logic [CW-1:0] run_q;
	logic [CW-1:0] first_q;
	logic [31:0]   word_q;
	logic [4:0]    bit_q;
	logic [CW-1:0] cur_q;
	logic [16:0]   rem_q;
	logic          fill_q;
	logic [AW-1:0] clr_q;

	bpa_pkg::status_t out_status_q;
	logic [15:0]      out_page_q;

	// bitmap memory, set bit = free page
	logic [31:0]   map_mem [bpa_pkg::MAP_WORDS];
	logic [31:0]   rdata_q;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_wdata;

	logic [SW-1:0] hi_word;
	logic [SW-1:0] end_word;
	logic [CW-1:0] word_base;
	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] run_p32;
	logic [CW-1:0] run_p1;
	logic [4:0]    off;
	logic [5:0]    avail;
	logic [5:0]    take;
	logic [32:0]   low_mask;
	logic [31:0]   run_mask;
	logic [31:0]   mark_word;
	logic [AW-1:0] cur_word;

	assign hi_word   = SW'(hi_q[16:5]);
	assign end_word  = (hi_word > SW'(bpa_pkg::MAP_WORDS)) ? SW'(bpa_pkg::MAP_WORDS) : hi_word;
	assign word_base = CW'({w_q, 5'd0});
	assign cnt_ext   = CW'(cnt_q);
	assign run_p32   = run_q + CW'(32);
	assign run_p1    = run_q + CW'(1);
	assign cur_word  = cur_q[AW+4:5];

	// bits of the current word covered by the remaining run
	assign off       = cur_q[4:0];
	assign avail     = 6'd32 - {1'b0, off};
	assign take      = (rem_q < 17'(avail)) ? rem_q[5:0] : avail;
	assign low_mask  = (33'd1 << take) - 33'd1;
	assign run_mask  = low_mask[31:0] << off;
	assign mark_word = fill_q ? (rdata_q | run_mask) : (rdata_q & ~run_mask);

	always_comb begin
		st.clr_last  = (clr_q == AW'(bpa_pkg::MAP_WORDS - 1));
		st.op        = op_q;
		st.alloc_bad = strict_q && ((cnt_q == 17'd0) || (lo_q < min_page_q) ||
			(hi_q > max_page_q));
		st.free_bad  = strict_q && (sp_q == 16'd0);
		st.scan_done = (w_q >= end_word);
		st.word_zero = (rdata_q == bpa_pkg::WORD_EMPTY);
		st.word_full = (rdata_q == bpa_pkg::WORD_FULL);
		st.full_hit  = (run_p32 >= cnt_ext);
		st.bit_hit   = word_q[bit_q] && (run_p1 >= cnt_ext);
		st.bit_last  = (bit_q == 5'd31);
		st.mark_done = (rem_q == 17'd0) || (cur_q >= CW'(bpa_pkg::MAP_PAGES));
	end

	assign mem_we    = cmd.clr_step || cmd.mark_write;
	assign mem_waddr = cmd.clr_step ? clr_q : cur_word;
	assign mem_wdata = cmd.clr_step ? bpa_pkg::WORD_EMPTY : mark_word;
	assign mem_re    = cmd.scan_read || cmd.mark_read;
	assign mem_raddr = cmd.scan_read ? w_q[AW-1:0] : cur_word;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= map_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q   <= 1'b1;
			min_page_q <= '0;
			max_page_q <= bpa_pkg::MAX_PAGE_RESET;
			clr_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bpa_pkg::REG_STRICT:   strict_q   <= cfg_wdata[0];
					bpa_pkg::REG_MIN_PAGE: min_page_q <= cfg_wdata;
					bpa_pkg::REG_MAX_PAGE: max_page_q <= cfg_wdata;
					default: begin
						strict_q <= strict_q;
					end
				endcase
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= in_command;
			sp_q  <= in_start_page;
			cnt_q <= in_page_count;
			lo_q  <= in_lower_page;
			hi_q  <= in_upper_page;
		end
		if (cmd.scan_init) begin
			w_q     <= SW'(lo_q[16:5]);
			run_q   <= '0;
			first_q <= '0;
		end
		if (cmd.scan_next) begin
			w_q <= w_q + SW'(1);
		end
		if (cmd.scan_word) begin
			word_q <= rdata_q;
			bit_q  <= 5'd0;
			if (st.word_zero) begin
				run_q <= '0;
			end else if (st.word_full) begin
				if (run_q == '0) begin
					first_q <= word_base;
				end
				run_q <= run_p32;
			end
		end
		if (cmd.scan_bit) begin
			bit_q <= bit_q + 5'd1;
			if (word_q[bit_q]) begin
				if (run_q == '0) begin
					first_q <= word_base + CW'(bit_q);
				end
				run_q <= run_p1;
			end else begin
				run_q <= '0;
			end
		end
		if (cmd.mark_init_alloc) begin
			cur_q  <= first_q;
			rem_q  <= cnt_q;
			fill_q <= 1'b0;
		end
		if (cmd.mark_init_req) begin
			cur_q  <= CW'(sp_q);
			rem_q  <= cnt_q;
			fill_q <= cmd.mark_fill;
		end
		if (cmd.mark_write) begin
			cur_q <= cur_q + CW'(take);
			rem_q <= rem_q - 17'(take);
		end
		if (cmd.load_out) begin
			out_status_q <= cmd.out_status;
			out_page_q   <= cmd.out_found ? first_q[15:0] : 16'd0;
		end
	end

	assign out_status = out_status_q;
	assign out_page   = out_page_q;

endmodule

// ----- design/bpa_checker.sv -----
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the bitmap page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [1:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bpa_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [1:0]                    m_tuser
);

	// one command at a time: no new transaction right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a command is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	// failed commands report page zero
	a_fail_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != bpa_pkg::ST_OK)) |-> (m_tdata == '0))
		else $error("nonzero page on a failed command");

	// a result is only loaded while the input side is closed
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while block was idle");

	// command is known once a transaction is taken
	a_cmd_known: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !$isunknown(s_tuser))
		else $error("unknown command bits on an accepted transaction");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
